@@ rtl/point_projection_to_ndc_core_macros.svh @@
// assertion helpers for the projection core
`ifndef POINT_PROJECTION_TO_NDC_CORE_MACROS_SVH
`define POINT_PROJECTION_TO_NDC_CORE_MACROS_SVH
`define PPN_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PPN_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

@@ rtl/ppn_pkg.sv @@
package ppn_pkg;
	localparam int FB = 16;
	// dividend is clip << 16, 48 bits magnitude
	localparam int DW = 48;
	localparam int RW = DW + 1;
	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = -32'sh7fffffff - 32'sd1;
	localparam logic [2:0] REG_COUNT = 3'd7;

	// one lane of the divider row: partial remainder, shifting dividend, quotient and sign
	typedef struct packed {
		logic [RW-1:0] rem;
		logic [DW-1:0] num;
		logic [DW-1:0] quo;
		logic          neg;
	} lane_t;

	typedef struct packed {
		logic          valid;
		logic [DW-1:0] den;
		logic          wz;
		logic          sat;
		lane_t [2:0]   lane;
	} word_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v,
		output logic s);
		s = 1'b0;
		if (v > 50'(Q_MAX)) begin
			s = 1'b1;
			return Q_MAX;
		end
		if (v < 50'(Q_MIN)) begin
			s = 1'b1;
			return Q_MIN;
		end
		return v[31:0];
	endfunction
endpackage

@@ rtl/ppn_div_cell.sv @@
// one restoring-division step for three lanes sharing a divisor
module ppn_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  ppn_pkg::word_t  d,
	output ppn_pkg::word_t  q
);
	ppn_pkg::word_t nxt;
	logic [ppn_pkg::RW-1:0] sh;
	logic [ppn_pkg::RW:0] diff;

	always_comb begin
		nxt = d;
		sh = '0;
		diff = '0;
		for (int i = 0; i < 3; i++) begin
			sh = {d.lane[i].rem[ppn_pkg::RW-2:0], d.lane[i].num[ppn_pkg::DW-1]};
			diff = {1'b0, sh} - {2'b00, d.den};
			nxt.lane[i].num = {d.lane[i].num[ppn_pkg::DW-2:0], 1'b0};
			if (!diff[ppn_pkg::RW]) begin
				nxt.lane[i].rem = diff[ppn_pkg::RW-1:0];
				nxt.lane[i].quo = {d.lane[i].quo[ppn_pkg::DW-2:0], 1'b1};
			end else begin
				nxt.lane[i].rem = sh;
				nxt.lane[i].quo = {d.lane[i].quo[ppn_pkg::DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else begin
			q <= nxt;
		end
	end
endmodule

@@ rtl/ppn_clip.sv @@
// matrix multiply: products in stage 1, rounded sums in stage 2
module ppn_clip (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_y,
	input  logic signed [31:0] world_z,
	input  logic [3:0][2:0][31:0] m_rows,
	input  logic [3:0][31:0]   t_rows,
	output logic               valid_s2,
	output logic signed [3:0][31:0] clip_s2,
	output logic               sat_s2
);
	logic valid_s1;
	logic signed [63:0] prod_s1 [4][3];
	logic signed [31:0] t_s1 [4];
	logic signed [31:0] p [3];

	assign p[0] = world_x;
	assign p[1] = world_y;
	assign p[2] = world_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			t_s1[r] <= t_rows[r];
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= p[c] * $signed(m_rows[r][c]);
			end
		end
	end

	// three full Q32.32 products plus translation need 66 bits
	logic signed [65:0] sum [4];
	logic signed [31:0] cl [4];
	logic s [4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			sum[r] = 66'(prod_s1[r][0]) + 66'(prod_s1[r][1]) + 66'(prod_s1[r][2])
				+ $signed({{18{t_s1[r][31]}}, t_s1[r], 16'h0}) + 66'sh8000;
			cl[r] = ppn_pkg::sat32(sum[r][65:ppn_pkg::FB], s[r]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			clip_s2[r] <= cl[r];
		end
		sat_s2 <= s[0] | s[1] | s[2] | s[3];
	end
endmodule

@@ rtl/point_projection_to_ndc_core.sv @@
// Projects one Q16.16 point per cycle through a 4x4 matrix and a divide by w.
// Drive world_x/y/z with start; busy is always low, so a point is taken every
// cycle that start is high. The matrix sits in eight 64-bit registers written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no
// point is in flight, which the block itself does not enforce; every 3-bit
// index is accepted. Pipeline: two multiply-add stages, one setup stage, 48
// divider cells and one output stage. Throughput is one point per cycle; the
// row of divider cells, one quotient bit each, sets the latency.
// done is high for one cycle with ndc_x/y/z, w_zero and saturated; the
// receiver cannot stall and a word is never held.
// Reset clears all words in flight and loads the identity matrix.
`include "point_projection_to_ndc_core_macros.svh"
module point_projection_to_ndc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] world_x,
	input  logic signed [31:0] world_y,
	input  logic signed [31:0] world_z,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] ndc_x,
	output logic signed [31:0] ndc_y,
	output logic signed [31:0] ndc_z,
	output logic               w_zero,
	output logic               saturated
);
	localparam int DW = ppn_pkg::DW;
	logic [7:0][63:0] regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= {64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
				64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};
		end else if (cfg_we && cfg_index <= ppn_pkg::REG_COUNT) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	logic [3:0][2:0][31:0] m_rows;
	logic [3:0][31:0] t_rows;
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				m_rows[r][c] = regs_q[c*2 + r/2][(r%2)*32 +: 32];
			end
			t_rows[r] = regs_q[6 + r/2][(r%2)*32 +: 32];
		end
	end

	assign busy = 1'b0;

	logic valid_s2, sat_s2;
	logic signed [3:0][31:0] clip_s2;

	ppn_clip u_clip (
		.clk, .arst_n, .start, .world_x, .world_y, .world_z,
		.m_rows, .t_rows, .valid_s2, .clip_s2, .sat_s2
	);

	// setup: magnitudes and signs for the divider row
	ppn_pkg::word_t head_s3;
	ppn_pkg::word_t head_d;
	ppn_pkg::word_t row [DW+1];
	logic [31:0] wmag;
	logic [31:0] cmag [3];
	always_comb begin
		wmag = clip_s2[3][31] ? 32'(-clip_s2[3]) : clip_s2[3];
		head_d.valid = valid_s2;
		head_d.den = {16'h0, wmag};
		head_d.wz = clip_s2[3] == '0;
		head_d.sat = sat_s2;
		for (int i = 0; i < 3; i++) begin
			cmag[i] = clip_s2[i][31] ? 32'(-clip_s2[i]) : clip_s2[i];
			head_d.lane[i].rem = '0;
			head_d.lane[i].quo = '0;
			head_d.lane[i].num = {cmag[i], 16'h0};
			head_d.lane[i].neg = clip_s2[i][31] ^ clip_s2[3][31];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s3 <= '0;
		end else begin
			head_s3 <= head_d;
		end
	end

	assign row[0] = head_s3;
	for (genvar g = 0; g < DW; g++) begin : g_cell
		ppn_div_cell u_cell (.clk, .arst_n, .d(row[g]), .q(row[g+1]));
	end

	ppn_pkg::word_t tail;
	assign tail = row[DW];
	logic signed [49:0] sq [3];
	logic signed [31:0] res [3];
	logic s [3];
	logic any_sat;
	always_comb begin
		any_sat = tail.sat;
		for (int i = 0; i < 3; i++) begin
			sq[i] = tail.lane[i].neg ? -$signed({2'b00, tail.lane[i].quo})
				: $signed({2'b00, tail.lane[i].quo});
			res[i] = ppn_pkg::sat32(sq[i], s[i]);
			if (tail.wz) begin
				res[i] = '0;
			end else begin
				any_sat = any_sat | s[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		ndc_x <= res[0];
		ndc_y <= res[1];
		ndc_z <= res[2];
		w_zero <= tail.wz;
		saturated <= any_sat;
	end

	`PPN_ASSERT_NXT(a_zero_out, clk, arst_n, tail.valid && tail.wz, ndc_x == 0 && ndc_y == 0 && ndc_z == 0 && w_zero, "w zero output not cleared")
	`PPN_ASSERT_IMP(a_busy_low, clk, arst_n, 1'b1, !busy, "busy raised")
	`PPN_ASSERT_NXT(a_head, clk, arst_n, valid_s2, head_s3.valid, "word lost at setup")
endmodule

@@ sim/tb_point_projection_to_ndc_core.sv @@
module tb_point_projection_to_ndc_core;
	typedef enum logic [2:0] {
		COL0_ROWS01, COL0_ROWS23, COL1_ROWS01, COL1_ROWS23,
		COL2_ROWS01, COL2_ROWS23, COL3_ROWS01, COL3_ROWS23
	} mat_reg_e;

	typedef enum int {MAT_IDENT, MAT_WZERO, MAT_HUGE, MAT_NEGW, MAT_HALF} mat_set_e;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               wz;
		logic               sat;
	} ndc_t;

	typedef struct {
		mat_set_e           mset;
		logic signed [31:0] x, y, z;
		bit                 typed;
		ndc_t               res;
	} vec_t;

	localparam int DRAIN = 60;
	localparam int LIMIT = 400000;

	logic clk, arst_n, start, busy, cfg_we, done, w_zero, saturated;
	logic signed [31:0] world_x, world_y, world_z, ndc_x, ndc_y, ndc_z;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	logic [63:0] mat_regs [8];
	ndc_t ndc_q [$];
	int errors, cycles, idle_pct;

	point_projection_to_ndc_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] entry(int c, int r);
		return mat_regs[c * 2 + r / 2][(r % 2) * 32 +: 32];
	endfunction

	function automatic logic signed [31:0] clamp(input logic signed [79:0] v, inout logic s);
		if (v > 80'(ppn_pkg::Q_MAX)) begin
			s = 1'b1;
			return ppn_pkg::Q_MAX;
		end
		if (v < 80'(ppn_pkg::Q_MIN)) begin
			s = 1'b1;
			return ppn_pkg::Q_MIN;
		end
		return v[31:0];
	endfunction

	function automatic ndc_t project(logic signed [31:0] px, py, pz);
		logic signed [79:0] acc;
		logic signed [31:0] clip [4];
		logic signed [63:0] quo;
		logic s;
		ndc_t o;
		s = 1'b0;
		for (int r = 0; r < 4; r++) begin
			acc = px * entry(0, r) + py * entry(1, r) + pz * entry(2, r)
				+ (80'(entry(3, r)) <<< 16) + 80'sh8000;
			clip[r] = clamp(acc >>> 16, s);
		end
		o = '0;
		o.wz = (clip[3] == 0);
		if (!o.wz) begin
			quo = (64'(clip[0]) <<< 16) / 64'(clip[3]);
			o.x = clamp(80'(quo), s);
			quo = (64'(clip[1]) <<< 16) / 64'(clip[3]);
			o.y = clamp(80'(quo), s);
			quo = (64'(clip[2]) <<< 16) / 64'(clip[3]);
			o.z = clamp(80'(quo), s);
		end
		o.sat = s;
		return o;
	endfunction

	// write all eight registers back to back; block must be idle
	task automatic load_matrix(logic [63:0] vals [8]);
		wait (ndc_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= mat_reg_e'(i);
			cfg_data <= vals[i];
			mat_regs[i] = vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic load_set(mat_set_e m);
		logic [63:0] v [8];
		v[COL0_ROWS01] = 64'h0000_0000_0001_0000;
		v[COL0_ROWS23] = '0;
		v[COL1_ROWS01] = 64'h0001_0000_0000_0000;
		v[COL1_ROWS23] = '0;
		v[COL2_ROWS01] = '0;
		v[COL2_ROWS23] = 64'h0000_0000_0001_0000;
		v[COL3_ROWS01] = '0;
		v[COL3_ROWS23] = 64'h0001_0000_0000_0000;
		case (m)
			MAT_WZERO: v[COL3_ROWS23] = '0;
			MAT_HUGE: begin
				for (int i = 0; i < 8; i++) v[i] = 64'h7fff_ffff_7fff_ffff;
				v[COL3_ROWS23] = 64'h0000_0001_7fff_ffff;
				v[COL0_ROWS23] = 64'h0000_0000_7fff_ffff;
				v[COL1_ROWS23] = 64'h0000_0000_8000_0000;
				v[COL2_ROWS23] = 64'h0000_0000_ffff_ffff;
			end
			MAT_NEGW: v[COL3_ROWS23] = 64'hffff_0000_8000_0000;
			MAT_HALF: begin
				v[COL0_ROWS01] = 64'hffff_8000_0000_8000;
				v[COL3_ROWS01] = 64'h8000_0000_7fff_ffff;
			end
			default: ;
		endcase
		load_matrix(v);
	endtask

	task automatic send(logic signed [31:0] x, y, z, bit typed, ndc_t res);
		logic b;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		ndc_q.push_back(typed ? res : project(x, y, z));
		start <= 1'b1;
		world_x <= x;
		world_y <= y;
		world_z <= z;
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $signed($urandom_range(32'h7_ffff)) - 32'sh4_0000;
			2: return $urandom_range(1) ? ppn_pkg::Q_MAX : ppn_pkg::Q_MIN;
			default: return $signed($urandom_range(32'h3f_ffff)) - 32'sh20_0000;
		endcase
	endfunction

	task automatic random_matrix();
		logic [63:0] v [8];
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < 8; i++) begin
			case (kind)
				0: v[i] = {$urandom(), $urandom()};
				1: v[i] = 64'hffff_ffff_ffff_ffff;
				2: v[i] = 64'h8000_0000_8000_0000;
				default: v[i] = {32'($signed($urandom_range(32'h3_ffff)) - 32'sh2_0000),
					32'($signed($urandom_range(32'h3_ffff)) - 32'sh2_0000)};
			endcase
		end
		// keep the w row small so device values stay in range
		if (kind > 2) begin
			v[COL0_ROWS23][63:32] = $signed($urandom_range(32'h1fff)) - 32'sh1000;
			v[COL1_ROWS23][63:32] = $signed($urandom_range(32'h1fff)) - 32'sh1000;
			v[COL2_ROWS23][63:32] = $signed($urandom_range(32'h1fff)) - 32'sh1000;
			v[COL3_ROWS23][63:32] = $urandom_range(4) == 0 ? 32'h0 :
				$signed($urandom_range(32'h3_ffff)) - 32'sh2_0000;
		end
		load_matrix(v);
	endtask

	always @(posedge clk) begin
		ndc_t got, want;
		if (done) begin
			got = '{ndc_x, ndc_y, ndc_z, w_zero, saturated};
			if (ndc_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: x=%h y=%h z=%h wz=%b sat=%b",
						got.x, got.y, got.z, got.wz, got.sat);
			end else begin
				want = ndc_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp x=%h y=%h z=%h wz=%b sat=%b, got x=%h y=%h z=%h wz=%b sat=%b",
							want.x, want.y, want.z, want.wz, want.sat,
							got.x, got.y, got.z, got.wz, got.sat);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("point_projection_to_ndc_core test failed");
			$finish;
		end
	end

	vec_t dir_tab [] = '{
		'{MAT_IDENT, 32'sh0, 32'sh0, 32'sh0, 1, '{32'sh0, 32'sh0, 32'sh0, 1'b0, 1'b0}},
		'{MAT_IDENT, ppn_pkg::Q_MAX, ppn_pkg::Q_MIN, ppn_pkg::Q_MAX, 1,
			'{ppn_pkg::Q_MAX, ppn_pkg::Q_MIN, ppn_pkg::Q_MAX, 1'b0, 1'b0}},
		'{MAT_IDENT, ppn_pkg::Q_MIN, ppn_pkg::Q_MAX, ppn_pkg::Q_MIN, 1,
			'{ppn_pkg::Q_MIN, ppn_pkg::Q_MAX, ppn_pkg::Q_MIN, 1'b0, 1'b0}},
		'{MAT_IDENT, 32'sh1, -32'sh1, 32'sh10000, 1, '{32'sh1, -32'sh1, 32'sh10000, 1'b0, 1'b0}},
		'{MAT_IDENT, -32'sh10000, 32'sh12345678, -32'sh5555, 1,
			'{-32'sh10000, 32'sh12345678, -32'sh5555, 1'b0, 1'b0}},
		'{MAT_WZERO, 32'sh10000, 32'sh20000, 32'sh30000, 1, '{32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0}},
		'{MAT_WZERO, ppn_pkg::Q_MAX, ppn_pkg::Q_MIN, 32'sh0, 1,
			'{32'sh0, 32'sh0, 32'sh0, 1'b1, 1'b0}},
		'{MAT_HUGE, ppn_pkg::Q_MAX, ppn_pkg::Q_MAX, ppn_pkg::Q_MAX, 0, '{default: '0}},
		'{MAT_HUGE, ppn_pkg::Q_MIN, ppn_pkg::Q_MIN, ppn_pkg::Q_MIN, 0, '{default: '0}},
		'{MAT_HUGE, 32'sh1, 32'sh0, -32'sh1, 0, '{default: '0}},
		'{MAT_HUGE, 32'sh0, 32'sh0, 32'sh0, 0, '{default: '0}},
		'{MAT_NEGW, 32'sh30000, -32'sh7, ppn_pkg::Q_MAX, 0, '{default: '0}},
		'{MAT_NEGW, ppn_pkg::Q_MIN, 32'sh1, 32'sh0, 0, '{default: '0}},
		'{MAT_HALF, 32'sh1, 32'sh1, 32'sh1, 0, '{default: '0}},
		'{MAT_HALF, -32'sh1, -32'sh3, 32'sh0, 0, '{default: '0}},
		'{MAT_HALF, 32'sh3, ppn_pkg::Q_MAX, ppn_pkg::Q_MIN, 0, '{default: '0}},
		'{MAT_HALF, ppn_pkg::Q_MAX, 32'sh5, 32'sh1, 0, '{default: '0}}
	};

	initial begin
		mat_set_e cur;
		int pidx;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_we = 1'b0;
		cfg_index = COL0_ROWS01;
		cfg_data = '0;
		world_x = '0;
		world_y = '0;
		world_z = '0;
		errors = 0;
		cycles = 0;
		idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// hold the reset matrix in the model too
		for (int i = 0; i < 8; i++) mat_regs[i] = '0;
		mat_regs[COL0_ROWS01] = 64'h0000_0000_0001_0000;
		mat_regs[COL1_ROWS01] = 64'h0001_0000_0000_0000;
		mat_regs[COL2_ROWS23] = 64'h0000_0000_0001_0000;
		mat_regs[COL3_ROWS23] = 64'h0001_0000_0000_0000;
		cur = MAT_IDENT;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].mset != cur) begin
				start <= 1'b0;
				cur = dir_tab[i].mset;
				load_set(cur);
			end
			send(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed, dir_tab[i].res);
		end
		for (int ph = 0; ph < 26; ph++) begin
			start <= 1'b0;
			random_matrix();
			pidx = ph % 3;
			idle_pct = pidx == 0 ? 0 : (pidx == 1 ? 69 : 20);
			for (int k = 0; k < 25; k++) begin
				send(rand_coord(), rand_coord(), rand_coord(), 0, '0);
				// drain the pipe once mid-phase
				if (ph == 4 && k == 12) begin
					start <= 1'b0;
					wait (ndc_q.size() == 0);
					@(posedge clk);
				end
			end
		end
		start <= 1'b0;
		wait (ndc_q.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("point_projection_to_ndc_core test passed");
		else
			$display("point_projection_to_ndc_core test failed");
		$finish;
	end
endmodule

@@ point_projection_to_ndc_core.f @@
+incdir+rtl
rtl/ppn_pkg.sv
rtl/ppn_div_cell.sv
rtl/ppn_clip.sv
rtl/point_projection_to_ndc_core.sv
sim/tb_point_projection_to_ndc_core.sv
